### sv/dntp_pkg.sv
// Shared types and constants for the decimal number text parser.
// Holds channel payload structs, the character class code and queue sizing.
// No dependencies.
`default_nettype none

package dntp_pkg;

  localparam int MAX_DIGITS = 18;
  localparam int DIGITS_W   = 5;
  localparam int CNT_W      = 14;
  localparam logic [CNT_W-1:0] CNT_MAX = 14'd16383;
  localparam int SIG_W      = 60;
  localparam int SCALE_W    = 16;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LOW_E = 8'h65;
  localparam logic [7:0] CH_UP_E  = 8'h45;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_POINT = 8'h2e;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;

  typedef enum logic [2:0] {
    CLS_DIGIT,
    CLS_SPACE,
    CLS_MINUS,
    CLS_PLUS,
    CLS_POINT,
    CLS_EXP,
    CLS_OTHER
  } char_cls_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic                      is_negative;
    logic [SIG_W-1:0]          significand;
    logic signed [SCALE_W-1:0] decimal_scale;
    logic                      range_clamped;
  } out_item_t;

  // classified character as it travels through the queue
  typedef struct packed {
    char_cls_t  cls;
    logic [3:0] digit;
    logic       last;
  } tok_t;

  typedef struct packed {
    logic                  empty;
    logic                  full;
    logic [FIFO_CNT_W-1:0] count;
  } fifo_status_t;

endpackage

`default_nettype wire

### sv/decimal_number_text_parser_unit.sv
// Top level of the decimal number text parser: classifier, token queue, parser.
// Depends on dntp_pkg, dntp_front, dntp_fifo and dntp_back.
//
//   port group   direction  payload      handshake
//   in_*         input      in_item_t    in_valid / in_stall
//   out_*        output     out_item_t   out_valid / out_stall
//
// One character per cycle while in_stall is low; the parser retires one queued token a cycle unless stalled.
// With the queue empty, the end-marked character is first written into the queue; popping it then registers out_valid.
// Synchronous active-low reset empties the queue and returns the parser to whitespace.
// While out_stall holds a result, characters without the end mark keep draining;
// an end-marked character waits in the 4-entry queue, and in_stall rises once it is full.
`default_nettype none

module decimal_number_text_parser_unit
  import dntp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  tok_t         front_tok;
  tok_t         head_tok;
  fifo_status_t fifo_st;
  logic         push;
  logic         pop;

  assign in_stall = fifo_st.full;
  assign push     = in_valid && !fifo_st.full;

  dntp_front u_front (
    .in_data (in_data),
    .tok     (front_tok)
  );

  dntp_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_tok (front_tok),
    .pop      (pop),
    .head_tok (head_tok),
    .status   (fifo_st)
  );

  dntp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_avail (!fifo_st.empty),
    .tok       (head_tok),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  a_fifo_bound : assert property (@(posedge clk) disable iff (!rst_n)
    fifo_st.count <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("token queue count beyond depth");

  a_fifo_flags : assert property (@(posedge clk) disable iff (!rst_n)
    !(fifo_st.full && fifo_st.empty))
    else $error("token queue both full and empty");

  a_sig_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.significand < 60'd1000000000000000000))
    else $error("significand holds more than the kept digit count");

endmodule

`default_nettype wire

### sv/dntp_front.sv
// Front end: classifies each incoming character into a token.
// Depends on dntp_pkg.
`default_nettype none

module dntp_front
  import dntp_pkg::*;
(
  input  in_item_t in_data,
  output tok_t     tok
);

  logic [7:0] c;

  assign c = in_data.char_code;

  always_comb begin
    tok.last  = in_data.end_of_string;
    tok.digit = 4'd0;
    if (c inside {[CH_ZERO:CH_NINE]}) begin
      tok.cls   = CLS_DIGIT;
      tok.digit = c[3:0];
    end else if (c inside {CH_SPACE, [CH_TAB:CH_CR]}) begin
      tok.cls = CLS_SPACE;
    end else if (c == CH_MINUS) begin
      tok.cls = CLS_MINUS;
    end else if (c == CH_PLUS) begin
      tok.cls = CLS_PLUS;
    end else if (c == CH_POINT) begin
      tok.cls = CLS_POINT;
    end else if (c inside {CH_LOW_E, CH_UP_E}) begin
      tok.cls = CLS_EXP;
    end else begin
      tok.cls = CLS_OTHER;
    end
  end

endmodule

`default_nettype wire

### sv/dntp_fifo.sv
// Short token queue between the classifier and the parser.
// Depends on dntp_pkg.
`default_nettype none

module dntp_fifo
  import dntp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  tok_t         push_tok,
  input  logic         pop,
  output tok_t         head_tok,
  output fifo_status_t status
);

  tok_t                  mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_tok;
    end
  end

  assign head_tok     = mem[rd_ptr_r];
  assign status.count = count_r;
  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == FIFO_CNT_W'(FIFO_DEPTH));

endmodule

`default_nettype wire

### sv/dntp_back.sv
// Back end: parse state machine, digit accumulator, scale build and result register.
// Depends on dntp_pkg.
`default_nettype none

module dntp_back
  import dntp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      tok_avail,
  input  tok_t      tok,
  output logic      pop,
  output logic      out_valid,
  output out_item_t out_data,
  input  logic      out_stall
);

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_INT,
    PH_FRAC,
    PH_EXPSIGN,
    PH_EXPDIG,
    PH_STOP
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic                minus_r, minus_nxt;
  logic [SIG_W-1:0]    acc_r, acc_nxt;
  logic [DIGITS_W-1:0] kept_r, kept_nxt;
  logic [CNT_W-1:0]    ovf_r, ovf_nxt;
  logic [DIGITS_W-1:0] frac_r, frac_nxt;
  logic                exp_neg_r, exp_neg_nxt;
  logic [CNT_W-1:0]    exp_r, exp_nxt;
  logic                clamp_r, clamp_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;

  logic [SIG_W-1:0]    acc_step;
  logic [CNT_W+3:0]    exp_step;
  logic                room;
  logic                emit;
  logic signed [SCALE_W:0] exp_s;
  logic signed [SCALE_W:0] scale;

  // one decimal step: x*10 + d as two shifts and adds
  assign acc_step = {acc_r[SIG_W-4:0], 3'b000} + {acc_r[SIG_W-2:0], 1'b0}
                    + SIG_W'(tok.digit);
  assign exp_step = {1'b0, exp_r, 3'b000} + {3'b000, exp_r, 1'b0}
                    + (CNT_W+4)'(tok.digit);
  assign room     = (kept_r < DIGITS_W'(MAX_DIGITS));

  // a terminating token waits while an unread result is stalled
  assign pop  = tok_avail && (!tok.last || !out_valid_r || !out_stall);
  assign emit = pop && tok.last;

  always_comb begin
    phase_nxt   = phase_r;
    minus_nxt   = minus_r;
    acc_nxt     = acc_r;
    kept_nxt    = kept_r;
    ovf_nxt     = ovf_r;
    frac_nxt    = frac_r;
    exp_neg_nxt = exp_neg_r;
    exp_nxt     = exp_r;
    clamp_nxt   = clamp_r;

    if (pop) begin
      case (phase_r)
        PH_SPACE, PH_INT: begin
          case (tok.cls)
            CLS_DIGIT: begin
              phase_nxt = PH_INT;
              if (room) begin
                acc_nxt = acc_step;
                if (acc_step != '0) begin
                  kept_nxt = kept_r + 1'b1;
                end
              end else if (ovf_r < CNT_MAX) begin
                ovf_nxt = ovf_r + 1'b1;
              end else begin
                clamp_nxt = 1'b1;
              end
            end
            CLS_SPACE: begin
              if (phase_r != PH_SPACE) begin
                phase_nxt = PH_STOP;
              end
            end
            CLS_MINUS: begin
              if (phase_r == PH_SPACE) begin
                minus_nxt = 1'b1;
                phase_nxt = PH_INT;
              end else begin
                phase_nxt = PH_STOP;
              end
            end
            CLS_PLUS: phase_nxt = (phase_r == PH_SPACE) ? PH_INT : PH_STOP;
            CLS_POINT: phase_nxt = PH_FRAC;
            CLS_EXP: phase_nxt = PH_EXPSIGN;
            default: phase_nxt = PH_STOP;
          endcase
        end
        PH_FRAC: begin
          case (tok.cls)
            CLS_DIGIT: begin
              if (room) begin
                acc_nxt  = acc_step;
                kept_nxt = kept_r + 1'b1;
                frac_nxt = frac_r + 1'b1;
              end
            end
            CLS_EXP: phase_nxt = PH_EXPSIGN;
            default: phase_nxt = PH_STOP;
          endcase
        end
        PH_EXPSIGN, PH_EXPDIG: begin
          if (tok.cls == CLS_DIGIT) begin
            phase_nxt = PH_EXPDIG;
            if (exp_step > (CNT_W+4)'(CNT_MAX)) begin
              exp_nxt   = CNT_MAX;
              clamp_nxt = 1'b1;
            end else begin
              exp_nxt = exp_step[CNT_W-1:0];
            end
          end else if (phase_r == PH_EXPSIGN && tok.cls == CLS_MINUS) begin
            exp_neg_nxt = 1'b1;
            phase_nxt   = PH_EXPDIG;
          end else if (phase_r == PH_EXPSIGN && tok.cls == CLS_PLUS) begin
            phase_nxt = PH_EXPDIG;
          end else begin
            phase_nxt = PH_STOP;
          end
        end
        default: phase_nxt = PH_STOP;
      endcase
    end
  end

  // scale = +/-exponent + overflow digits - fraction digits, saturated to 16 bits
  always_comb begin
    exp_s = $signed({3'b000, exp_nxt});
    if (exp_neg_nxt) begin
      exp_s = -exp_s;
    end
    scale = exp_s + $signed({3'b000, ovf_nxt})
                  - $signed({{(SCALE_W+1-DIGITS_W){1'b0}}, frac_nxt});

    out_data_nxt.is_negative   = minus_nxt;
    out_data_nxt.significand   = acc_nxt;
    out_data_nxt.range_clamped = clamp_nxt;
    out_data_nxt.decimal_scale = scale[SCALE_W-1:0];
    if (scale > 17'sd32767) begin
      out_data_nxt.decimal_scale = 16'sh7fff;
      out_data_nxt.range_clamped = 1'b1;
    end else if (scale < -17'sd32768) begin
      out_data_nxt.decimal_scale = 16'sh8000;
      out_data_nxt.range_clamped = 1'b1;
    end

    out_valid_nxt = out_valid_r && out_stall;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || emit) begin
      phase_r   <= PH_SPACE;
      minus_r   <= 1'b0;
      acc_r     <= '0;
      kept_r    <= '0;
      ovf_r     <= '0;
      frac_r    <= '0;
      exp_neg_r <= 1'b0;
      exp_r     <= '0;
      clamp_r   <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      minus_r   <= minus_nxt;
      acc_r     <= acc_nxt;
      kept_r    <= kept_nxt;
      ovf_r     <= ovf_nxt;
      frac_r    <= frac_nxt;
      exp_neg_r <= exp_neg_nxt;
      exp_r     <= exp_nxt;
      clamp_r   <= clamp_nxt;
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (emit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
